// ===== design/brd_pkg.sv =====
package brd_pkg;

    // Command kinds carried in s_tuser
    typedef enum logic [2:0] {
        OP_PUSH_TAIL = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_POP       = 3'd2,
        OP_DRAIN     = 3'd3,
        OP_SHUTDOWN  = 3'd4
    } brd_op_t;

    // Result status carried in m_tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHUT  = 2'd2,
        ST_EMPTY = 2'd3
    } brd_status_t;

    localparam int unsigned CFG_W    = 9;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned DEPTH_W  = 9;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned OUT_USER_W = 2;
    localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

    // Everything about one command except the popped handle
    typedef struct packed {
        brd_status_t        status;
        logic               take;
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] peak;
        logic               shut;
    } brd_result_t;

endpackage

// ===== design/bounded_ring_deque.sv =====
// Channel  Dir  Signals                          Contents (lowest bit first)
// cfg      in   cfg_valid/cfg_ready/cfg_data     capacity_in_use[8:0]
// s_axis   in   s_tvalid/s_tready/s_tdata/tuser  tdata: item_value[31:0]; tuser: opcode[2:0]
// m_axis   out  m_tvalid/m_tready/m_tdata/tuser  tdata: popped_value, depth, peak_depth,
//                                                 is_shut_down, zero pad; tuser: status
//
// One command per cycle sustained while m_tready keeps up; a result is held first in the
// stage register, beside the slot memory's registered read, then in the output register.
// Pointers, count, peak and the shutdown flag update at the accept edge, so back-to-back
// commands see each other's effects without forwarding.
// Reset clears pointers, count, peak and flag and loads capacity 256; the slot memory is
// not cleared, so there is no start-up sweep.
// A stalled result holds in the output register; one more item waits in the stage behind
// it, after which s_tready drops.
module bounded_ring_deque
    import brd_pkg::*;
#(
    parameter int unsigned MAX_SLOTS    = 256,
    parameter int unsigned HANDLE_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,    // capacity_in_use
    // command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // item_value[31:0]
    input  logic [IN_USER_W-1:0]  s_tuser,     // opcode[2:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // popped_value[31:0], depth[40:32],
                                               // peak_depth[49:41], is_shut_down[50], 0s
    output logic [OUT_USER_W-1:0] m_tuser      // status[1:0]
);

    localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
    localparam int unsigned PAD_W = OUT_DATA_W - VALUE_W - 2 * DEPTH_W - 1;

    logic                    cmd_fire;
    brd_result_t             cmd_res;
    logic                    ram_we;
    logic [IW-1:0]           ram_wr_addr;
    logic [HANDLE_WIDTH-1:0] ram_wr_data;
    logic                    ram_re;
    logic [IW-1:0]           ram_rd_addr;
    logic [HANDLE_WIDTH-1:0] ram_rd_data;

    logic                    pend_valid_reg;
    brd_result_t             pend_res_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [OUT_USER_W-1:0]   out_user_reg;
    logic                    out_load;
    logic [VALUE_W-1:0]      popped;

    assign cfg_ready = 1'b1;

    // advance the stage into the output register whenever that register frees up
    assign out_load = pend_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~pend_valid_reg | out_load;
    assign cmd_fire = s_tvalid & s_tready;

    brd_ctrl #(
        .MAX_SLOTS    (MAX_SLOTS),
        .HANDLE_WIDTH (HANDLE_WIDTH),
        .IW           (IW),
        .CW           (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .cmd_fire    (cmd_fire),
        .opcode      (s_tuser),
        .item_value  (s_tdata),
        .result      (cmd_res),
        .ram_we      (ram_we),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_re      (ram_re),
        .ram_rd_addr (ram_rd_addr)
    );

    brd_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (HANDLE_WIDTH),
        .AW    (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // memory data only counts for a successful pop or drain
    assign popped = pend_res_reg.take ? VALUE_W'(ram_rd_data) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            pend_res_reg <= cmd_res;
        end
        if (out_load)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, pend_res_reg.shut, pend_res_reg.peak,
                             pend_res_reg.depth, popped};
            out_user_reg <= pend_res_reg.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> pend_valid_reg)
        else $error("accepted item lost before the stage");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !out_load) |-> !s_tready)
        else $error("stage would be overwritten");

endmodule

// ===== design/brd_slot_ram.sv =====
module brd_slot_ram
    import brd_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = 8
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/brd_ctrl.sv =====
module brd_ctrl
    import brd_pkg::*;
#(
    parameter int unsigned MAX_SLOTS    = 256,
    parameter int unsigned HANDLE_WIDTH = 32,
    parameter int unsigned IW           = 8,
    parameter int unsigned CW           = 9
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    cmd_fire,
    input  logic [IN_USER_W-1:0]    opcode,
    input  logic [VALUE_W-1:0]      item_value,
    output brd_result_t             result,
    output logic                    ram_we,
    output logic [IW-1:0]           ram_wr_addr,
    output logic [HANDLE_WIDTH-1:0] ram_wr_data,
    output logic                    ram_re,
    output logic [IW-1:0]           ram_rd_addr
);

    logic [CFG_W-1:0] cap_reg;
    logic [CW-1:0]    cap_eff;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    peak_reg, peak_next;
    logic             shut_reg, shut_next;
    logic             full;
    logic [IW-1:0]    head_back;
    brd_status_t      status;
    logic             take;
    logic             do_wr;
    logic             do_rd;

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
        logic [IW:0] n;
        n = (IW+1)'(idx) + (IW+1)'(1);
        return (n >= cap) ? '0 : n[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] idx,
                                                input logic [CW-1:0] cap);
        if (idx == '0 || idx >= cap)
        begin
            return IW'(cap - CW'(1));
        end
        return idx - IW'(1);
    endfunction

    // clamp the capacity register into 1..MAX_SLOTS
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(cap_reg) > MAX_SLOTS)
        begin
            cap_eff = CW'(MAX_SLOTS);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    assign full      = (count_reg >= cap_eff);
    assign head_back = step_down(head_reg, cap_eff);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        shut_next   = shut_reg;
        status      = ST_OK;
        take        = 1'b0;
        do_wr       = 1'b0;
        do_rd       = 1'b0;
        ram_wr_addr = tail_reg;
        unique case (opcode) inside
            OP_PUSH_TAIL:
            begin
                if (shut_reg)
                begin
                    status = ST_SHUT;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_wr      = 1'b1;
                    tail_next  = step_up(tail_reg, cap_eff);
                    count_next = count_reg + CW'(1);
                end
            end
            OP_PUSH_HEAD:
            begin
                if (shut_reg)
                begin
                    status = ST_SHUT;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_wr       = 1'b1;
                    ram_wr_addr = head_back;
                    head_next   = head_back;
                    count_next  = count_reg + CW'(1);
                end
            end
            OP_POP, OP_DRAIN:
            begin
                if (opcode == OP_POP && shut_reg)
                begin
                    status = ST_SHUT;
                end
                else if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    do_rd      = 1'b1;
                    take       = 1'b1;
                    head_next  = step_up(head_reg, cap_eff);
                    count_next = count_reg - CW'(1);
                end
            end
            OP_SHUTDOWN:
            begin
                shut_next = 1'b1;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        peak_next = (count_next > peak_reg) ? count_next : peak_reg;
    end

    assign ram_we      = cmd_fire & do_wr;
    assign ram_re      = cmd_fire & do_rd;
    assign ram_rd_addr = head_reg;
    assign ram_wr_data = HANDLE_WIDTH'(item_value);

    assign result.status = status;
    assign result.take   = take;
    assign result.depth  = DEPTH_W'(count_next);
    assign result.peak   = DEPTH_W'(peak_next);
    assign result.shut   = shut_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
            shut_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd_fire)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                peak_reg  <= peak_next;
                shut_reg  <= shut_next;
            end
        end
    end

    a_shut_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        shut_reg |=> shut_reg)
        else $error("shutdown flag cleared");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_SLOTS && peak_reg >= count_reg)
        else $error("item count out of range or above peak");

    a_wr_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("slot write and read in the same command");

endmodule

// ===== bench/bounded_ring_deque_test.sv =====
module bounded_ring_deque_test;

    timeunit 1ns;
    timeprecision 1ps;

    import brd_pkg::*;

    localparam int unsigned SLOTS       = 256;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 60;   // receiver hold-off that fills the block
    localparam int unsigned SETTLE      = 8;    // settle margin after the last owed result

    // One result as the block should report it
    typedef struct {
        brd_status_t        status;
        logic [31:0]        popped;
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] peak;
        logic               shut;
    } deque_result_t;

    // Shadow deque: tracks pointers, count, peak and the shutdown flag, and holds
    // the results still owed by the block, oldest first.
    class deque_scoreboard;
        logic [31:0]      slots [SLOTS];
        int unsigned      head;
        int unsigned      tail;
        int unsigned      count;
        int unsigned      peak;
        bit               stopped;
        logic [CFG_W-1:0] capacity;
        deque_result_t    owed [$];
        int unsigned      errors;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            head     = 0;
            tail     = 0;
            count    = 0;
            peak     = 0;
            stopped  = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity = value;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction

        // Work out the outcome of one accepted command and queue it
        function void note_command(logic [2:0] op, logic [31:0] value);
            int unsigned   cap;
            deque_result_t r;
            cap = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
            r.status = ST_OK;
            r.popped = '0;
            case (op) inside
                OP_PUSH_TAIL, OP_PUSH_HEAD:
                begin
                    if (stopped)
                        r.status = ST_SHUT;
                    else if (count >= cap)
                        r.status = ST_FULL;
                    else if (op == OP_PUSH_TAIL)
                    begin
                        slots[tail % SLOTS] = value;
                        tail = (tail + 1 >= cap) ? 0 : tail + 1;
                        count++;
                    end
                    else
                    begin
                        // step back: wrap from 0 or from beyond the capacity to the top slot
                        head = (head == 0 || head >= cap) ? cap - 1 : head - 1;
                        slots[head % SLOTS] = value;
                        count++;
                    end
                end
                OP_POP, OP_DRAIN:
                begin
                    if (op == OP_POP && stopped)
                        r.status = ST_SHUT;
                    else if (count == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.popped = slots[head % SLOTS];
                        head = (head + 1 >= cap) ? 0 : head + 1;
                        count--;
                    end
                end
                OP_SHUTDOWN:
                    stopped = 1;
                default:
                    ;   // unused opcodes leave everything as it is
            endcase
            if (count > peak)
                peak = count;
            r.depth = count[DEPTH_W-1:0];
            r.peak  = peak[DEPTH_W-1:0];
            r.shut  = stopped;
            owed.push_back(r);
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data);
            deque_result_t r;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d data %0h",
                         $time, user, data);
                errors++;
                return;
            end
            r = owed.pop_front();
            compare("status", 32'(r.status), 32'(user));
            compare("popped_value", r.popped, data[31:0]);
            compare("depth", 32'(r.depth), 32'(data[40:32]));
            compare("peak_depth", 32'(r.peak), 32'(data[49:41]));
            compare("is_shut_down", 32'(r.shut), 32'(data[50]));
            compare("pad", 32'd0, 32'(data[OUT_DATA_W-1:51]));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // item_value[31:0]
    logic [IN_USER_W-1:0]  s_tuser;     // opcode[2:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // popped_value, depth, peak_depth, is_shut_down, zeros
    logic [OUT_USER_W-1:0] m_tuser;     // status[1:0]

    deque_scoreboard sb;
    bit              idle_on;        // random gaps and stalls allowed
    bit              long_hold_req;  // ask the receiver for one long hold-off
    int unsigned     cycles;

    bounded_ring_deque DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Watchdog: end the run as failed if it reaches CYCLE_LIMIT
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("bounded_ring_deque test failed");
                $finish;
            end
        end
    end

    // Receiver: decide m_tready at each falling edge. The long hold-off is counted
    // here so that the sender keeps offering items while the block backs up.
    initial
    begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 0;
                hold_left     = LONG_HOLD - 1;
                m_tready      = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                m_tready   = 1'b0;
            end
            else
                m_tready = 1'b1;
        end
    end

    // Check every result taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Offer one command; hold it until accepted, then note it in the shadow deque.
    // A gap lowers tvalid at one falling edge and raises it at a later one.
    task automatic send_cmd(logic [2:0] op, logic [31:0] value);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = value;
        s_tuser  = op;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(op, value);
    endtask

    // Stop the stream and wait until every owed result has come back
    task automatic settle_block();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        settle_block();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_capacity(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Weighted random command: pushes at push_pct, then pops and drains, and a
    // sprinkling of unused opcodes
    function automatic logic [2:0] pick_op(int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return ($urandom_range(0, 2) == 0) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        else if (r < 97)
            return ($urandom_range(0, 2) == 0) ? OP_DRAIN : OP_POP;
        else
            return 3'($urandom_range(5, 7));
    endfunction

    initial
    begin
        logic [CFG_W-1:0] caps [13];
        int unsigned      push_pct;
        sb            = new();
        idle_on       = 1;
        long_hold_req = 0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        caps = '{9'd1, 9'd2, 9'd0, 9'd511, 9'd3, 9'd300, 9'd5, 9'd256,
                 9'd8, 9'd255, 9'd16, 9'd1, 9'd40};

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_capacity(9'd256);

        // Directed: empty refusals, extreme handles, head wrap back from slot 0,
        // unused opcodes
        send_cmd(OP_POP, 32'h0000_0000);
        send_cmd(OP_DRAIN, 32'hFFFF_FFFF);
        send_cmd(OP_PUSH_TAIL, 32'h0000_0000);
        send_cmd(OP_PUSH_TAIL, 32'hFFFF_FFFF);
        send_cmd(OP_PUSH_HEAD, 32'h8000_0001);
        send_cmd(OP_PUSH_HEAD, 32'h7FFF_FFFE);
        send_cmd(3'd5, 32'h1234_5678);
        send_cmd(3'd6, 32'hA5A5_A5A5);
        send_cmd(3'd7, 32'hFFFF_FFFF);
        send_cmd(OP_POP, 32'h0);
        send_cmd(OP_DRAIN, 32'h0);
        send_cmd(OP_POP, 32'h0);
        send_cmd(OP_POP, 32'h0);
        send_cmd(OP_POP, 32'h0);

        // Fill every slot once at full capacity, so that no pop after a capacity
        // change can land on a slot that was never written. Hold the receiver off
        // at the start so the block backs up and stalls its input.
        long_hold_req = 1;
        repeat (SLOTS)
            send_cmd(OP_PUSH_TAIL, $urandom());
        send_cmd(OP_PUSH_TAIL, $urandom());
        send_cmd(OP_PUSH_HEAD, $urandom());
        repeat (SLOTS + 1)
            send_cmd(($urandom_range(0, 1) == 0) ? OP_POP : OP_DRAIN, 32'($urandom()));

        // Random phases over a spread of capacities; the queue is not emptied between
        // them, so each change lands on live pointers and count
        foreach (caps[i])
        begin
            write_capacity(caps[i]);
            repeat (2)
            begin
                push_pct = $urandom_range(25, 75);
                repeat (35)
                    send_cmd(pick_op(push_pct), $urandom());
            end
        end

        // Last part: no idling. Shutdown, then pushes and pops refused while drains still serve.
        idle_on = 0;
        send_cmd(OP_PUSH_TAIL, $urandom());
        send_cmd(OP_PUSH_HEAD, $urandom());
        send_cmd(OP_SHUTDOWN, $urandom());
        send_cmd(OP_PUSH_TAIL, $urandom());
        send_cmd(OP_PUSH_HEAD, $urandom());
        send_cmd(OP_POP, $urandom());
        // drain everything, then one more on the empty queue
        repeat (sb.count + 1)
            send_cmd(OP_DRAIN, $urandom());
        send_cmd(OP_POP, $urandom());
        send_cmd(OP_SHUTDOWN, $urandom());
        repeat (40)
            send_cmd(3'($urandom_range(0, 7)), $urandom());

        settle_block();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("bounded_ring_deque test passed");
        else
            $display("bounded_ring_deque test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/brd_pkg.sv
design/brd_slot_ram.sv
design/brd_ctrl.sv
design/bounded_ring_deque.sv
bench/bounded_ring_deque_test.sv
